// File: sv/cba_pkg.sv
// Shared types and constants for the contiguous block allocator.
// No dependencies; used by cba_ctrl, cba_dpath and contiguous_block_allocator.
`default_nettype none

package cba_pkg;

   localparam int SIZE_W   = 12;
   localparam int FIRST_W  = 5;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 2;
   // reciprocal used for the byte-to-block division is below 2**(SIZE_W+1)
   localparam int RECIP_W  = SIZE_W + 1;

   typedef logic [SIZE_W-1:0]   size_type;
   typedef logic [SIZE_W:0]     size_sum_type;
   typedef logic [FIRST_W-1:0]  first_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_NOFIT = 2'd1;
   localparam status_type ST_BAD   = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic       load_prod;
      logic       scan_init;
      logic       scan_step;
      logic       mark_free_init;
      logic       mark_alloc_init;
      logic       write_step;
      logic       set_result;
      status_type result_status;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic blocks_zero;
      logic too_big;
      logic free_bad;
      logic hit;
      logic scan_miss;
      logic mark_last;
      logic clear_last;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// File: sv/cba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                     wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

`default_nettype wire

// File: sv/cba_ctrl.sv
// Controller state machine of the contiguous block allocator.
// Depends on cba_pkg for the command and status structs and status codes.
`default_nettype none

module cba_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cba_pkg::stat_type stat,
   output cba_pkg::cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_MARK  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.write_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.load_prod = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (stat.blocks_zero) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = cba_pkg::ST_BAD;
               state_in          = S_DONE;
            end else if (!stat.is_free) begin
               if (stat.too_big) begin
                  cmd.set_result    = 1'b1;
                  cmd.result_status = cba_pkg::ST_NOFIT;
                  state_in          = S_DONE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
            end else if (stat.free_bad) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = cba_pkg::ST_BAD;
               state_in          = S_DONE;
            end else begin
               cmd.mark_free_init = 1'b1;
               cmd.set_result     = 1'b1;
               cmd.result_status  = cba_pkg::ST_OK;
               state_in           = S_MARK;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) begin
               cmd.mark_alloc_init = 1'b1;
               cmd.set_result      = 1'b1;
               cmd.result_status   = cba_pkg::ST_OK;
               state_in            = S_MARK;
            end else if (stat.scan_miss) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = cba_pkg::ST_NOFIT;
               state_in          = S_DONE;
            end
         end
         S_MARK: begin
            cmd.write_step = 1'b1;
            if (stat.mark_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to empty
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/cba_dpath.sv
// Datapath of the contiguous block allocator: request registers, byte-to-block
// division, free-map RAM with scan and mark counters, result and output registers.
// Depends on cba_pkg and cba_ram.
`default_nettype none

module cba_dpath #(
   parameter int NUM_BLOCKS  = 32,
   parameter int BLOCK_BYTES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cba_pkg::cmd_type    cmd,
   output cba_pkg::stat_type        stat,
   input  wire logic                req_action,
   input  wire cba_pkg::size_type   req_size_bytes,
   input  wire cba_pkg::first_type  req_first_block,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output cba_pkg::status_type      rsp_status,
   output cba_pkg::slot_type        rsp_slot
);

   localparam int IW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int RW    = $clog2(NUM_BLOCKS + 1);
   localparam int SH    = cba_pkg::SIZE_W + $clog2(BLOCK_BYTES);
   localparam int RECIP = ((1 << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
   localparam int PW    = cba_pkg::SIZE_W + cba_pkg::RECIP_W;

   localparam logic [IW-1:0]              LAST_IDX = IW'(NUM_BLOCKS - 1);
   localparam cba_pkg::size_type          NUM_SZ   = cba_pkg::size_type'(NUM_BLOCKS);
   localparam cba_pkg::size_sum_type      NUM_SUM  = cba_pkg::size_sum_type'(NUM_BLOCKS);
   localparam logic [PW-1:0]              RECIP_PW = PW'(RECIP);

   logic                 action_ff;
   cba_pkg::size_type    size_ff;
   cba_pkg::first_type   first_ff;
   logic [PW-1:0]        prod_ff;
   cba_pkg::size_type    blocks;

   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic          dvld_ff, dvld_in;
   logic          issued_ff, issued_in;
   logic [RW-1:0] run_ff, run_in;
   logic [IW-1:0] start_ff, start_in;
   logic [RW-1:0] cnt_ff, cnt_in;
   logic          fill_ff, fill_in;

   cba_pkg::status_type status_ff;
   cba_pkg::slot_type   slot_ff;
   logic                rsp_valid_ff;
   cba_pkg::status_type rsp_status_ff;
   cba_pkg::slot_type   rsp_slot_ff;

   logic          ram_rdata;
   logic [IW-1:0] hit_start;
   logic          hit;
   cba_pkg::size_type first_sz;

   cba_ram #(
      .WIDTH(1),
      .DEPTH(NUM_BLOCKS)
   ) u_map (
      .clock(clock),
      .we   (cmd.write_step),
      .waddr(idx_ff),
      .wdata(fill_ff),
      .raddr(idx_ff),
      .rdata(ram_rdata)
   );

   // floor(bytes / BLOCK_BYTES) as multiply by a rounded-up reciprocal and shift
   assign blocks    = cba_pkg::size_type'(prod_ff >> SH);
   assign first_sz  = cba_pkg::size_type'(first_ff);
   assign hit_start = (run_ff == '0) ? pidx_ff : start_ff;
   assign hit       = dvld_ff && ram_rdata &&
                      (cba_pkg::size_type'(run_ff) + cba_pkg::size_type'(1) == blocks);

   always_comb begin
      stat.is_free     = (action_ff == cba_pkg::ACT_FREE);
      stat.blocks_zero = (blocks == '0);
      stat.too_big     = (blocks > NUM_SZ);
      stat.free_bad    = (first_sz >= NUM_SZ) ||
                         ({1'b0, blocks} + {1'b0, first_sz} > NUM_SUM);
      stat.hit         = hit;
      stat.scan_miss   = dvld_ff && !hit && (pidx_ff == LAST_IDX);
      stat.mark_last   = (cba_pkg::size_type'(cnt_ff) + cba_pkg::size_type'(1) == blocks);
      stat.clear_last  = (idx_ff == LAST_IDX);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      idx_in    = idx_ff;
      pidx_in   = pidx_ff;
      dvld_in   = dvld_ff;
      issued_in = issued_ff;
      run_in    = run_ff;
      start_in  = start_ff;
      cnt_in    = cnt_ff;
      fill_in   = fill_ff;
      if (cmd.scan_init) begin
         idx_in    = '0;
         dvld_in   = 1'b0;
         issued_in = 1'b0;
         run_in    = '0;
      end
      if (cmd.scan_step) begin
         // read one block per cycle; the data returns in the next cycle
         dvld_in = !issued_ff;
         pidx_in = idx_ff;
         if (idx_ff == LAST_IDX) begin
            issued_in = 1'b1;
         end else begin
            idx_in = IW'(idx_ff + 1'b1);
         end
         if (dvld_ff) begin
            if (ram_rdata) begin
               run_in   = RW'(run_ff + 1'b1);
               start_in = hit_start;
            end else begin
               run_in = '0;
            end
         end
      end
      if (cmd.mark_free_init) begin
         idx_in  = IW'(first_ff);
         cnt_in  = '0;
         fill_in = 1'b1;
      end
      if (cmd.mark_alloc_init) begin
         idx_in  = hit_start;
         cnt_in  = '0;
         fill_in = 1'b0;
      end
      if (cmd.write_step) begin
         idx_in = IW'(idx_ff + 1'b1);
         cnt_in = RW'(cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         dvld_ff   <= 1'b0;
         issued_ff <= 1'b0;
         fill_ff   <= 1'b1;
      end else begin
         idx_ff    <= idx_in;
         dvld_ff   <= dvld_in;
         issued_ff <= issued_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff  <= pidx_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      cnt_ff   <= cnt_in;
      if (cmd.load_req) begin
         action_ff <= req_action;
         size_ff   <= req_size_bytes;
         first_ff  <= req_first_block;
      end
      if (cmd.load_prod) begin
         prod_ff <= PW'(size_ff) * RECIP_PW;
      end
      if (cmd.set_result) begin
         status_ff <= cmd.result_status;
         slot_ff   <= cmd.mark_alloc_init ? cba_pkg::slot_type'(hit_start) : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

`default_nettype wire

// File: sv/contiguous_block_allocator.sv
// First-fit contiguous block allocator. One word in, one word out, one item at a time.
// Allocation scans the free-map RAM at one block per cycle, then marks the found run of blocks;
// a free marks its blocks without a scan, and a refused request writes nothing.
// A finished word waits in the output register while the next is taken.
// Reset: synchronous; a clearing pass sets every block free,
// with req_ready low until it ends.
`default_nettype none

module contiguous_block_allocator #(
   parameter int NUM_BLOCKS  = 32,
   parameter int BLOCK_BYTES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_action,
   input  wire cba_pkg::size_type   req_size_bytes,
   input  wire cba_pkg::first_type  req_first_block,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output cba_pkg::status_type      rsp_status,
   output cba_pkg::slot_type        rsp_slot
);

   cba_pkg::cmd_type  cmd;
   cba_pkg::stat_type stat;

   cba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   cba_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_size_bytes (req_size_bytes),
      .req_first_block(req_first_block),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot)
   );

   a_refused_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cba_pkg::ST_OK) |-> rsp_slot == '0)
      else $error("refused word carries a nonzero slot");

   a_no_write_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.write_step)
      else $error("free map written while taking a new word");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in work");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid || rsp_ready)
      else $error("output register loaded while holding a word");

endmodule

`default_nettype wire
